[hdl/hrbt_pkg.sv]
package hrbt_pkg;

    // Parse phase, one-hot
    typedef enum logic [13:0] {
        PH_METHOD   = 14'b00_0000_0000_0001,
        PH_PRESPACE = 14'b00_0000_0000_0010,
        PH_PATH     = 14'b00_0000_0000_0100,
        PH_QUERY    = 14'b00_0000_0000_1000,
        PH_VERSION  = 14'b00_0000_0001_0000,
        PH_RL_CR    = 14'b00_0000_0010_0000,
        PH_LINE     = 14'b00_0000_0100_0000,
        PH_NAME     = 14'b00_0000_1000_0000,
        PH_HSPACE   = 14'b00_0001_0000_0000,
        PH_VALUE    = 14'b00_0010_0000_0000,
        PH_H_CR     = 14'b00_0100_0000_0000,
        PH_END_CR   = 14'b00_1000_0000_0000,
        PH_BODY     = 14'b01_0000_0000_0000,
        PH_ERROR    = 14'b10_0000_0000_0000
    } phase_t;

    typedef enum logic [2:0] {
        RGN_METHOD  = 3'd0,
        RGN_PATH    = 3'd1,
        RGN_QUERY   = 3'd2,
        RGN_VERSION = 3'd3,
        RGN_NAME    = 3'd4,
        RGN_VALUE   = 3'd5,
        RGN_BODY    = 3'd6,
        RGN_SEP     = 3'd7
    } region_t;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_OK   = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // header_index saturates here
    localparam logic [4:0] HDR_IDX_MAX = 5'd31;

endpackage

[hdl/http_request_byte_tagger.sv]
// HTTP/1.1 request byte tagger.
// Input channel: one request byte per transfer (byte_value), last_byte set on
// the final byte of a request. Output channel: the same byte as byte_out,
// tagged with its region (method, path, query, version, header name, header
// value, body or separator), the header_index for header bytes, final_flag
// and, on the final byte, status (ok or malformed).
// Both channels transfer a request when valid is high and stall is low.
// A byte accepted on the input channel is registered in the input stage,
// then tagged by the phase update and held in the output register, which
// raises out_valid. Throughput: one byte per cycle while out_stall is low.
// A stall on the output holds the output register; the input stage then also
// holds and in_stall follows, so no byte is lost or repeated.
// Reset clears both valid flags and puts the parser in the method phase with
// no headers counted. After each final byte the parser returns to that state,
// so the next byte starts a new request.
module http_request_byte_tagger #(
    parameter int MAX_HEADERS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_value,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] byte_out,
    output logic [2:0] region,
    output logic [4:0] header_index,
    output logic       final_flag,
    output logic [1:0] status
);
    import hrbt_pkg::*;

    // counter must hold MAX_HEADERS itself
    localparam int HW = $clog2(MAX_HEADERS + 1);

    // input stage
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // parser state
    phase_t        phase_reg, phase_next;
    logic [HW-1:0] hs_reg, hs_next;
    logic          err_reg, err_next;

    // output register
    logic       out_valid_reg;
    logic [7:0] byte_out_reg;
    logic [2:0] region_reg;
    logic [4:0] hidx_reg;
    logic       final_reg;
    logic [1:0] status_reg;

    logic out_free, s1_move, in_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // byte classes
    logic is_sp, is_cr, is_lf, is_q, is_colon;
    assign is_sp    = (s1_byte_reg == CH_SP);
    assign is_cr    = (s1_byte_reg == CH_CR);
    assign is_lf    = (s1_byte_reg == CH_LF);
    assign is_q     = (s1_byte_reg == CH_QUERY);
    assign is_colon = (s1_byte_reg == CH_COLON);

    logic limit_hit;
    assign limit_hit = (32'(hs_reg) >= 32'(MAX_HEADERS));

    // path byte: start of or inside the path
    phase_t  path_ph;
    region_t path_rgn;
    logic    path_open;
    always_comb
    begin
        path_rgn  = RGN_SEP;
        path_open = 1'b0;
        priority if (is_sp)
            path_ph = PH_VERSION;
        else if (is_q)
            path_ph = PH_QUERY;
        else if (is_cr)
            path_ph = PH_RL_CR;
        else if (is_lf)
            path_ph = PH_LINE;
        else
        begin
            path_ph   = PH_PATH;
            path_rgn  = RGN_PATH;
            path_open = 1'b1;
        end
    end

    // first byte of a header line
    phase_t  line_ph;
    region_t line_rgn;
    logic    line_open;
    always_comb
    begin
        line_rgn  = RGN_SEP;
        line_open = 1'b0;
        priority if (limit_hit)
        begin
            line_ph  = PH_BODY;
            line_rgn = RGN_BODY;
        end
        else if (is_cr)
            line_ph = PH_END_CR;
        else if (is_lf)
            line_ph = PH_BODY;
        else if (is_colon)
            line_ph = PH_HSPACE;
        else
        begin
            line_ph   = PH_NAME;
            line_rgn  = RGN_NAME;
            line_open = 1'b1;
        end
    end

    // header value byte; CR or LF closes the header
    phase_t  val_ph;
    region_t val_rgn;
    logic    val_inc;
    always_comb
    begin
        val_rgn = RGN_SEP;
        val_inc = 1'b0;
        priority if (is_cr)
        begin
            val_ph  = PH_H_CR;
            val_inc = 1'b1;
        end
        else if (is_lf)
        begin
            val_ph  = PH_LINE;
            val_inc = 1'b1;
        end
        else
        begin
            val_ph  = PH_VALUE;
            val_rgn = RGN_VALUE;
        end
    end

    // main phase step
    phase_t  step_ph;
    region_t rgn;
    logic    open_item, fail, hs_inc;
    always_comb
    begin
        step_ph   = phase_reg;
        rgn       = RGN_SEP;
        open_item = 1'b0;
        fail      = 1'b0;
        hs_inc    = 1'b0;
        unique case (phase_reg)
            PH_METHOD:
            begin
                open_item = 1'b1;
                priority if (is_sp)
                    step_ph = PH_PRESPACE;
                else if (is_cr || is_lf)
                    fail = 1'b1;
                else
                    rgn = RGN_METHOD;
            end
            PH_PRESPACE:
            begin
                if (is_sp)
                    open_item = 1'b1;
                else
                begin
                    step_ph   = path_ph;
                    rgn       = path_rgn;
                    open_item = path_open;
                end
            end
            PH_PATH:
            begin
                step_ph   = path_ph;
                rgn       = path_rgn;
                open_item = path_open;
            end
            PH_QUERY:
            begin
                priority if (is_sp)
                    step_ph = PH_VERSION;
                else if (is_cr)
                    step_ph = PH_RL_CR;
                else if (is_lf)
                    step_ph = PH_LINE;
                else
                    rgn = RGN_QUERY;
            end
            PH_VERSION:
            begin
                priority if (is_cr)
                    step_ph = PH_RL_CR;
                else if (is_lf)
                    step_ph = PH_LINE;
                else
                    rgn = RGN_VERSION;
            end
            PH_RL_CR, PH_H_CR:
            begin
                if (is_lf)
                    step_ph = PH_LINE;
                else
                begin
                    step_ph   = line_ph;
                    rgn       = line_rgn;
                    open_item = line_open;
                end
            end
            PH_LINE:
            begin
                step_ph   = line_ph;
                rgn       = line_rgn;
                open_item = line_open;
            end
            PH_NAME:
            begin
                priority if (is_colon)
                    step_ph = PH_HSPACE;
                else if (is_cr || is_lf)
                    fail = 1'b1;
                else
                begin
                    rgn       = RGN_NAME;
                    open_item = 1'b1;
                end
            end
            PH_HSPACE:
            begin
                if (!is_sp)
                begin
                    step_ph = val_ph;
                    rgn     = val_rgn;
                    hs_inc  = val_inc;
                end
            end
            PH_VALUE:
            begin
                step_ph = val_ph;
                rgn     = val_rgn;
                hs_inc  = val_inc;
            end
            PH_END_CR:
            begin
                step_ph = PH_BODY;
                if (!is_lf)
                    rgn = RGN_BODY;
            end
            PH_BODY:
                rgn = RGN_BODY;
            default:
                ; // error phase and unused codes: separator, stay put
        endcase
        if (fail)
            step_ph = PH_ERROR;
    end

    // header index, saturated
    logic [4:0] hidx;
    always_comb
    begin
        if (rgn == RGN_NAME || rgn == RGN_VALUE)
            hidx = (32'(hs_reg) > 32'(HDR_IDX_MAX)) ? HDR_IDX_MAX : 5'(hs_reg);
        else
            hidx = '0;
    end

    status_t st;
    always_comb
    begin
        if (!s1_last_reg)
            st = ST_BUSY;
        else if (err_reg || fail || open_item)
            st = ST_BAD;
        else
            st = ST_OK;
    end

    // final byte puts the parser back to its reset state
    always_comb
    begin
        if (s1_last_reg)
        begin
            phase_next = PH_METHOD;
            hs_next    = '0;
            err_next   = 1'b0;
        end
        else
        begin
            phase_next = step_ph;
            hs_next    = hs_inc ? hs_reg + 1'b1 : hs_reg;
            err_next   = err_reg || fail;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_METHOD;
            hs_reg        <= '0;
            err_reg       <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (s1_move)
            begin
                phase_reg <= phase_next;
                hs_reg    <= hs_next;
                err_reg   <= err_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= byte_value;
            s1_last_reg <= last_byte;
        end
        if (s1_move)
        begin
            byte_out_reg <= s1_byte_reg;
            region_reg   <= rgn;
            hidx_reg     <= hidx;
            final_reg    <= s1_last_reg;
            status_reg   <= st;
        end
    end

    assign out_valid    = out_valid_reg;
    assign byte_out     = byte_out_reg;
    assign region       = region_reg;
    assign header_index = hidx_reg;
    assign final_flag   = final_reg;
    assign status       = status_reg;

`ifndef ASSERT_OFF
    // status is only reported on the final byte
    a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !final_reg |-> status_reg == ST_BUSY)
        else $error("status set on a non-final byte");

    a_status_final_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && final_reg |-> (status_reg == ST_OK || status_reg == ST_BAD))
        else $error("final byte without a verdict");

    // header index only carried by header bytes
    a_hidx_region: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && hidx_reg != 5'd0
        |-> (region_reg == RGN_NAME || region_reg == RGN_VALUE))
        else $error("header index outside a header");

    // an error latches the error phase
    a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> phase_reg == PH_ERROR)
        else $error("error flag without error phase");

    // final byte restarts the parser
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && s1_last_reg |=> phase_reg == PH_METHOD && hs_reg == '0 && !err_reg)
        else $error("parser not restarted after final byte");

    // header counter never passes the limit
    a_hs_limit: assert property (@(posedge clk) disable iff (!rst_n)
        32'(hs_reg) <= 32'(MAX_HEADERS))
        else $error("header count beyond limit");
`endif

endmodule

[verif/http_request_byte_tagger_tb.sv]
`timescale 1ns / 1ps

module http_request_byte_tagger_tb;

    import hrbt_pkg::*;

    localparam int HDR_LIMIT = 32;

    // Tag expected for one byte: mirrors the output ports field by field
    typedef struct packed {
        logic [7:0] byte_out;
        region_t    region;
        logic [4:0] hdr_idx;
        logic       final_flag;
        status_t    status;
    } tag_t;

    // One request on the input channel. Where 'fixed' is set the tag in
    // 'want' was typed in by hand and overrides the predictor.
    typedef struct {
        logic [7:0] b;
        logic       fin;
        bit         fixed;
        tag_t       want;
    } byte_req_t;

    // Row of the directed table; byte_out and final_flag follow from b and fin
    typedef struct {
        logic [7:0] b;
        logic       fin;
        bit         fixed;
        region_t    rg;
        logic [4:0] idx;
        status_t    st;
    } dir_row_t;

    localparam int N_DIR = 26;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] byte_value = 8'd0;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] byte_out;
    logic [2:0] region;
    logic [4:0] header_index;
    logic       final_flag;
    logic [1:0] status;

    // Predictor state: parse phase, headers stored so far, sticky error
    phase_t     ps_phase = PH_METHOD;
    int         hdrs_seen = 0;
    bit         err_seen = 1'b0;

    byte_req_t  stim_q[$];
    tag_t       tags_due[$];
    byte_req_t  cur_req;
    dir_row_t   directed_tab [N_DIR];
    int         n_errors = 0;
    int         cyc = 0;

    // Both sides run without any idling or stalling in this window
    wire calm = (cyc >= 300 && cyc < 500);

    http_request_byte_tagger #(
        .MAX_HEADERS (HDR_LIMIT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_value   (byte_value),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_out     (byte_out),
        .region       (region),
        .header_index (header_index),
        .final_flag   (final_flag),
        .status       (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        cyc <= cyc + 1;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Byte at the start of, or inside, the path. Ending on a path byte
    // leaves the request line open, which is malformed.
    function automatic void path_step(input logic [7:0] b, inout region_t rg,
                                      inout bit unclosed);
        if (b == CH_SP)
            ps_phase = PH_VERSION;
        else if (b == CH_QUERY)
            ps_phase = PH_QUERY;
        else if (b == CH_CR)
            ps_phase = PH_RL_CR;
        else if (b == CH_LF)
            ps_phase = PH_LINE;
        else
        begin
            ps_phase = PH_PATH;
            rg = RGN_PATH;
            unclosed = 1'b1;
        end
    endfunction

    // First byte of a header line; past the header limit the rest is body
    function automatic void line_step(input logic [7:0] b, inout region_t rg,
                                      inout bit unclosed);
        if (hdrs_seen >= HDR_LIMIT)
        begin
            ps_phase = PH_BODY;
            rg = RGN_BODY;
        end
        else if (b == CH_CR)
            ps_phase = PH_END_CR;
        else if (b == CH_LF)
            ps_phase = PH_BODY;
        else if (b == CH_COLON)
            ps_phase = PH_HSPACE;
        else
        begin
            ps_phase = PH_NAME;
            rg = RGN_NAME;
            unclosed = 1'b1;
        end
    endfunction

    // Header value byte; CR or LF closes the header and counts it
    function automatic void value_step(input logic [7:0] b, inout region_t rg);
        if (b == CH_CR)
        begin
            hdrs_seen++;
            ps_phase = PH_H_CR;
        end
        else if (b == CH_LF)
        begin
            hdrs_seen++;
            ps_phase = PH_LINE;
        end
        else
        begin
            ps_phase = PH_VALUE;
            rg = RGN_VALUE;
        end
    endfunction

    function automatic tag_t tag_byte(input logic [7:0] b, input logic fin);
        tag_t    t;
        region_t rg;
        bit      unclosed;
        rg = RGN_SEP;
        unclosed = 1'b0;
        case (ps_phase)
            PH_METHOD:
            begin
                unclosed = 1'b1;
                if (b == CH_SP)
                    ps_phase = PH_PRESPACE;
                else if (b == CH_CR || b == CH_LF)
                begin
                    err_seen = 1'b1;
                    ps_phase = PH_ERROR;
                end
                else
                    rg = RGN_METHOD;
            end
            PH_PRESPACE:
            begin
                if (b == CH_SP)
                    unclosed = 1'b1;
                else
                    path_step(b, rg, unclosed);
            end
            PH_PATH:
                path_step(b, rg, unclosed);
            PH_QUERY:
            begin
                if (b == CH_SP)
                    ps_phase = PH_VERSION;
                else if (b == CH_CR)
                    ps_phase = PH_RL_CR;
                else if (b == CH_LF)
                    ps_phase = PH_LINE;
                else
                    rg = RGN_QUERY;
            end
            PH_VERSION:
            begin
                if (b == CH_CR)
                    ps_phase = PH_RL_CR;
                else if (b == CH_LF)
                    ps_phase = PH_LINE;
                else
                    rg = RGN_VERSION;
            end
            PH_RL_CR, PH_H_CR:
            begin
                if (b == CH_LF)
                    ps_phase = PH_LINE;
                else
                    line_step(b, rg, unclosed);
            end
            PH_LINE:
                line_step(b, rg, unclosed);
            PH_NAME:
            begin
                if (b == CH_COLON)
                    ps_phase = PH_HSPACE;
                else if (b == CH_CR || b == CH_LF)
                begin
                    err_seen = 1'b1;
                    ps_phase = PH_ERROR;
                end
                else
                begin
                    rg = RGN_NAME;
                    unclosed = 1'b1;
                end
            end
            PH_HSPACE:
            begin
                if (b != CH_SP)
                    value_step(b, rg);
            end
            PH_VALUE:
                value_step(b, rg);
            PH_END_CR:
            begin
                ps_phase = PH_BODY;
                if (b != CH_LF)
                    rg = RGN_BODY;
            end
            PH_BODY:
                rg = RGN_BODY;
            default:
                ;
        endcase

        t.byte_out = b;
        t.region = rg;
        t.hdr_idx = 5'd0;
        if (rg == RGN_NAME || rg == RGN_VALUE)
            t.hdr_idx = (hdrs_seen > 31) ? HDR_IDX_MAX : 5'(hdrs_seen);
        t.final_flag = fin;
        if (fin)
        begin
            t.status = (err_seen || unclosed) ? ST_BAD : ST_OK;
            ps_phase = PH_METHOD;
            hdrs_seen = 0;
            err_seen = 1'b0;
        end
        else
            t.status = ST_BUSY;
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    // Any byte that is not a delimiter of the request line or a header
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == CH_SP || b == CH_CR || b == CH_LF || b == CH_QUERY || b == CH_COLON);
        return b;
    endfunction

    function automatic logic [7:0] delim_byte();
        case ($urandom_range(0, 4))
            0:       return CH_CR;
            1:       return CH_LF;
            2:       return CH_SP;
            3:       return CH_QUERY;
            default: return CH_COLON;
        endcase
    endfunction

    task automatic push_text(ref logic [7:0] msg[$], input int n);
        repeat (n) msg.push_back(text_byte());
    endtask

    // Line end: mostly CR LF, sometimes a bare LF, now and then a bare CR
    task automatic push_eol(ref logic [7:0] msg[$]);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 9)
        begin
            if (pick < 6)
                msg.push_back(CH_CR);
            msg.push_back(CH_LF);
        end
        else
            msg.push_back(CH_CR);
    endtask

    // One HTTP message. Most are well formed with random content; some are
    // cut short or have a delimiter dropped in, and some are pure noise.
    // 'big' forces a header count around the header limit.
    task automatic add_message(input bit big);
        logic [7:0] msg[$];
        int         kind;
        int         n_hdr;
        int         hmax;
        byte_req_t  r;
        kind = $urandom_range(0, 99);
        if (!big && kind < 15)
        begin
            repeat ($urandom_range(1, 12))
                msg.push_back(($urandom_range(0, 9) < 4) ? delim_byte() : 8'($urandom));
        end
        else
        begin
            push_text(msg, $urandom_range(1, 6));
            repeat ($urandom_range(1, 2)) msg.push_back(CH_SP);
            push_text(msg, $urandom_range(0, 6));
            if ($urandom_range(0, 1))
            begin
                msg.push_back(CH_QUERY);
                push_text(msg, $urandom_range(0, 4));
            end
            if ($urandom_range(0, 5) != 0)
            begin
                msg.push_back(CH_SP);
                push_text(msg, $urandom_range(0, 8));
            end
            push_eol(msg);

            if (big)
                n_hdr = $urandom_range(HDR_LIMIT - 1, HDR_LIMIT + 2);
            else if ($urandom_range(0, 11) == 0)
                n_hdr = $urandom_range(HDR_LIMIT - 3, HDR_LIMIT + 2);
            else
                n_hdr = $urandom_range(0, 4);
            // keep long header lists short per line
            hmax = (n_hdr > 8) ? 2 : 6;
            repeat (n_hdr)
            begin
                push_text(msg, $urandom_range(0, hmax));
                msg.push_back(CH_COLON);
                repeat ($urandom_range(0, 2)) msg.push_back(CH_SP);
                push_text(msg, $urandom_range(0, hmax));
                push_eol(msg);
            end
            push_eol(msg);
            repeat ($urandom_range(0, 8)) msg.push_back(8'($urandom));

            if (!big && kind < 35)
            begin
                // broken: message ends early
                kind = $urandom_range(1, msg.size());
                while (msg.size() > kind)
                    void'(msg.pop_back());
            end
            else if (!big && kind < 45)
                msg[$urandom_range(0, msg.size() - 1)] = delim_byte();
        end

        foreach (msg[i])
        begin
            r.b = msg[i];
            r.fin = (i == msg.size() - 1);
            r.fixed = 1'b0;
            r.want = '0;
            stim_q.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitors
    // ------------------------------------------------------------------

    // Input side: every accepted request advances the predictor. Sampling
    // at the edge sees the values from before it, so ordering is safe.
    always @(posedge clk)
    begin : accept_mon
        tag_t guess;
        if (rst_n && in_valid && !in_stall)
        begin
            guess = tag_byte(byte_value, last_byte);
            tags_due.push_back(cur_req.fixed ? cur_req.want : guess);
        end
    end

    // Output side: compare each accepted request with the oldest tag due
    always @(posedge clk)
    begin : result_mon
        tag_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (tags_due.size() == 0)
            begin
                $error("unexpected output request: byte_out %0d", byte_out);
                n_errors++;
            end
            else
            begin
                want = tags_due.pop_front();
                if (byte_out !== want.byte_out)
                begin
                    $error("byte_out: expected %0d, got %0d", want.byte_out, byte_out);
                    n_errors++;
                end
                if (region !== want.region)
                begin
                    $error("region: expected %0d, got %0d", want.region, region);
                    n_errors++;
                end
                if (header_index !== want.hdr_idx)
                begin
                    $error("header_index: expected %0d, got %0d", want.hdr_idx, header_index);
                    n_errors++;
                end
                if (final_flag !== want.final_flag)
                begin
                    $error("final_flag: expected %0d, got %0d", want.final_flag, final_flag);
                    n_errors++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    n_errors++;
                end
            end
        end
    end

    // Receiver stalls at random, with a chance of 12 in 100, outside the calm window
    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= !calm && ($urandom_range(0, 99) < 12);
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        byte_req_t r;
        int        n_rand;

        // Directed part. Tags are typed in for the byte after reset, the
        // byte extremes at the end of a message, and the error outcomes;
        // everything else goes through the predictor.
        directed_tab = '{
            '{8'h47,    1'b0, 1'b1, RGN_METHOD, 5'd0, ST_BUSY}, // first byte after reset
            '{8'h45,    1'b0, 1'b0, RGN_SEP,    5'd0, ST_BUSY},
            '{CH_SP,    1'b0, 1'b0, RGN_SEP,    5'd0, ST_BUSY},
            '{CH_SP,    1'b0, 1'b0, RGN_SEP,    5'd0, ST_BUSY}, // extra space before path
            '{8'h2F,    1'b0, 1'b0, RGN_SEP,    5'd0, ST_BUSY},
            '{CH_QUERY, 1'b0, 1'b0, RGN_SEP,    5'd0, ST_BUSY},
            '{8'h71,    1'b0, 1'b0, RGN_SEP,    5'd0, ST_BUSY},
            '{CH_SP,    1'b0, 1'b0, RGN_SEP,    5'd0, ST_BUSY},
            '{8'h48,    1'b0, 1'b0, RGN_SEP,    5'd0, ST_BUSY},
            '{CH_CR,    1'b0, 1'b0, RGN_SEP,    5'd0, ST_BUSY},
            '{CH_LF,    1'b0, 1'b0, RGN_SEP,    5'd0, ST_BUSY},
            '{8'h48,    1'b0, 1'b0, RGN_SEP,    5'd0, ST_BUSY}, // header name
            '{CH_COLON, 1'b0, 1'b0, RGN_SEP,    5'd0, ST_BUSY},
            '{CH_SP,    1'b0, 1'b0, RGN_SEP,    5'd0, ST_BUSY},
            '{8'hFF,    1'b0, 1'b0, RGN_SEP,    5'd0, ST_BUSY}, // top byte in a value
            '{CH_CR,    1'b0, 1'b0, RGN_SEP,    5'd0, ST_BUSY},
            '{CH_LF,    1'b0, 1'b0, RGN_SEP,    5'd0, ST_BUSY},
            '{CH_COLON, 1'b0, 1'b0, RGN_SEP,    5'd0, ST_BUSY}, // empty name
            '{CH_LF,    1'b0, 1'b0, RGN_SEP,    5'd0, ST_BUSY}, // empty value, bare LF
            '{CH_CR,    1'b0, 1'b0, RGN_SEP,    5'd0, ST_BUSY}, // blank line
            '{CH_LF,    1'b0, 1'b0, RGN_SEP,    5'd0, ST_BUSY},
            '{8'h00,    1'b1, 1'b1, RGN_BODY,   5'd0, ST_OK},   // zero byte ends the body
            '{8'h41,    1'b0, 1'b1, RGN_METHOD, 5'd0, ST_BUSY},
            '{CH_LF,    1'b0, 1'b1, RGN_SEP,    5'd0, ST_BUSY}, // line end inside method
            '{8'h78,    1'b1, 1'b1, RGN_SEP,    5'd0, ST_BAD},  // error is sticky
            '{8'hFF,    1'b1, 1'b1, RGN_METHOD, 5'd0, ST_BAD}   // ends in the method
        };
        foreach (directed_tab[i])
        begin
            r.b = directed_tab[i].b;
            r.fin = directed_tab[i].fin;
            r.fixed = directed_tab[i].fixed;
            r.want = '{directed_tab[i].b, directed_tab[i].rg, directed_tab[i].idx,
                       directed_tab[i].fin, directed_tab[i].st};
            stim_q.push_back(r);
        end

        // Random part: the first message always has a header count around the header limit
        add_message(1'b1);
        n_rand = stim_q.size() - N_DIR;
        while (n_rand < 500)
        begin
            add_message(1'b0);
            n_rand = stim_q.size() - N_DIR;
        end

        cur_req = stim_q[0];
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One request per loop pass, with random idle cycles in front of it
        foreach (stim_q[i])
        begin
            while (!calm && $urandom_range(0, 99) < 12)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            byte_value <= stim_q[i].b;
            last_byte <= stim_q[i].fin;
            cur_req <= stim_q[i];
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
        end
        in_valid <= 1'b0;

        // Drain, then wait on to catch any stray output request
        while (tags_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (n_errors == 0)
            $display("http_request_byte_tagger_tb OK");
        else
            $display("http_request_byte_tagger_tb NOT OK");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("http_request_byte_tagger_tb NOT OK");
        $finish;
    end

endmodule
